// ===== src/life_grid_generation_engine_unit_macros.svh =====
// assertion macros for the life grid generation engine
// used by the top level only; needs no package
`ifndef LIFE_GRID_GENERATION_ENGINE_UNIT_MACROS_SVH
`define LIFE_GRID_GENERATION_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LGGE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lgge check failed");

// next-cycle implication, disabled while in reset
`define LGGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lgge check failed");

`endif

// ===== src/lgge_pkg.sv =====
// shared types and constants of the life grid generation engine
// no dependencies
`default_nettype none

package lgge_pkg;

    // field widths of a request
    localparam int unsigned OP_W       = 2;
    localparam int unsigned CELL_IDX_W = 6;

    // neighbour counts of the b3/s23 rule
    localparam int unsigned BIRTH_COUNT   = 3;
    localparam int unsigned SURVIVE_COUNT = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_WRITE   = 2'd1,
        OP_READ    = 2'd2,
        OP_ADVANCE = 2'd3
    } op_t;

endpackage

`default_nettype wire

// ===== src/lgge_req_if.sv =====
// request channel: valid/ready handshake with the operation and cell fields
// depends on lgge_pkg
`default_nettype none

interface lgge_req_if;
    logic                              valid;
    logic                              ready;
    logic [lgge_pkg::OP_W-1:0]         operation;
    logic [lgge_pkg::CELL_IDX_W-1:0]   cell_row;
    logic [lgge_pkg::CELL_IDX_W-1:0]   cell_col;
    logic                              cell_value;

    modport source (output valid, output operation, output cell_row, output cell_col,
                    output cell_value, input ready);
    modport sink   (input valid, input operation, input cell_row, input cell_col,
                    input cell_value, output ready);
endinterface

`default_nettype wire

// ===== src/lgge_rsp_if.sv =====
// response channel: valid/ready handshake with read value and done flag
// no dependencies
`default_nettype none

interface lgge_rsp_if;
    logic valid;
    logic ready;
    logic read_value;
    logic op_done;

    modport source (output valid, output read_value, output op_done, input ready);
    modport sink   (input valid, input read_value, input op_done, output ready);
endinterface

`default_nettype wire

// ===== src/lgge_row_mem.sv =====
// grid storage: one word per row, one write port, one read port
// read data is registered; no dependencies
`default_nettype none

module lgge_row_mem #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  wire logic                    clk,
    input  wire logic                    rd_en,
    input  wire logic [$clog2(ROWS)-1:0] rd_addr,
    output logic      [COLS-1:0]         rd_data,
    input  wire logic                    wr_en,
    input  wire logic [$clog2(ROWS)-1:0] wr_addr,
    input  wire logic [COLS-1:0]         wr_data
);

    logic [COLS-1:0] row_mem [ROWS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= row_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/lgge_rule.sv =====
// next-generation logic for one row word under the b3/s23 rule
// cells beyond the row ends count as dead; depends on lgge_pkg
`default_nettype none

module lgge_rule #(
    parameter int COLS = 64
) (
    input  wire logic [COLS-1:0] above,
    input  wire logic [COLS-1:0] cur,
    input  wire logic [COLS-1:0] below,
    output logic      [COLS-1:0] next_row
);

    // zero guard bit on each side of the three rows
    logic [COLS+1:0] above_pad;
    logic [COLS+1:0] cur_pad;
    logic [COLS+1:0] below_pad;

    assign above_pad = {1'b0, above, 1'b0};
    assign cur_pad   = {1'b0, cur,   1'b0};
    assign below_pad = {1'b0, below, 1'b0};

    for (genvar c = 0; c < COLS; c++)
    begin : g_col
        logic [3:0] nbr_cnt;

        // eight neighbours of column c
        assign nbr_cnt = 4'(above_pad[c]) + 4'(above_pad[c+1]) + 4'(above_pad[c+2])
                       + 4'(cur_pad[c])                         + 4'(cur_pad[c+2])
                       + 4'(below_pad[c]) + 4'(below_pad[c+1]) + 4'(below_pad[c+2]);

        // birth on three, survival on two or three
        assign next_row[c] = (nbr_cnt == 4'(lgge_pkg::BIRTH_COUNT))
                           || ((nbr_cnt == 4'(lgge_pkg::SURVIVE_COUNT)) && cur[c]);
    end

endmodule

`default_nettype wire

// ===== src/life_grid_generation_engine_unit.sv =====
// Life grid engine (b3/s23, no wrap), one request at a time.
// Cell read or write: accepted, the row word is fetched into the read register, then the cell is
// modified or read and the reply registered once rsp can take it. Clear: a pass zeroes every row,
// then a reply. Advance: a sweep of one row per cycle (rows fetched one ahead, written back one
// behind), then a reply. Reset: control clears at once; a clearing pass then zeroes the grid with
// req.ready low. Depends on lgge_pkg, both channels, lgge_row_mem, lgge_rule and the macros
`default_nettype none
`include "life_grid_generation_engine_unit_macros.svh"

module life_grid_generation_engine_unit #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lgge_req_if.sink    req,
    lgge_rsp_if.source  rsp
);

    localparam int RAW = $clog2(ROWS);
    localparam int CAW = $clog2(COLS);
    localparam int CW  = $clog2(ROWS + 1);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_ACCESS = 6'b000100,
        S_CLEAR  = 6'b001000,
        S_GEN    = 6'b010000,
        S_REPLY  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              read_value_reg, read_value_next;
    lgge_pkg::op_t     op_reg, op_next;
    logic [RAW-1:0]    row_idx_reg, row_idx_next;
    logic [CAW-1:0]    col_idx_reg, col_idx_next;
    logic              value_reg, value_next;
    logic              inside_reg, inside_next;
    logic [COLS-1:0]   above_reg, above_next;
    logic [COLS-1:0]   cur_reg, cur_next;

    logic              in_accept;
    logic              can_push;
    logic              push;
    lgge_pkg::op_t     in_op;
    logic [RAW+5:0]    row_wide;
    logic [CAW+5:0]    col_wide;
    logic              in_inside;
    logic [CW-1:0]     cnt_m1;
    logic [CW:0]       cnt_p1;
    logic              cnt_in_grid;

    logic              mem_rd_en;
    logic [RAW-1:0]    mem_rd_addr;
    logic [COLS-1:0]   mem_rd_data;
    logic              mem_wr_en;
    logic [RAW-1:0]    mem_wr_addr;
    logic [COLS-1:0]   mem_wr_data;
    logic [COLS-1:0]   below_row;
    logic [COLS-1:0]   gen_row;
    logic [COLS-1:0]   cell_bit;

    // row storage
    lgge_row_mem #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_row_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // next generation of the row behind the read pointer
    lgge_rule #(
        .COLS (COLS)
    ) u_rule (
        .above    (above_reg),
        .cur      (cur_reg),
        .below    (below_row),
        .next_row (gen_row)
    );

    // handshakes
    assign req.ready  = (state_reg == S_IDLE);
    assign in_accept  = req.valid && req.ready;
    assign can_push   = !out_valid_reg || rsp.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.op_done    = 1'b1;

    // request decode and cell address range check
    assign in_op     = lgge_pkg::op_t'(req.operation);
    assign row_wide  = (RAW+6)'(req.cell_row);
    assign col_wide  = (CAW+6)'(req.cell_col);
    assign in_inside = (32'(req.cell_row) < ROWS) && (32'(req.cell_col) < COLS);

    // sweep pointer arithmetic
    assign cnt_m1      = cnt_reg - CW'(1);
    assign cnt_p1      = (CW+1)'(cnt_reg) + (CW+1)'(1);
    assign cnt_in_grid = (cnt_reg < CW'(ROWS));
    assign below_row   = cnt_in_grid ? mem_rd_data : '0;
    assign cell_bit    = COLS'(1) << col_idx_reg;

    // control, memory ports and result register
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        read_value_next = read_value_reg;
        op_next         = op_reg;
        row_idx_next    = row_idx_reg;
        col_idx_next    = col_idx_reg;
        value_next      = value_reg;
        inside_next     = inside_reg;
        above_next      = above_reg;
        cur_next        = cur_reg;
        push            = 1'b0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = row_wide[RAW-1:0];
        mem_wr_en       = 1'b0;
        mem_wr_addr     = cnt_reg[RAW-1:0];
        mem_wr_data     = '0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                // post-reset clearing pass
                mem_wr_en = 1'b1;
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(ROWS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next      = in_op;
                    row_idx_next = row_wide[RAW-1:0];
                    col_idx_next = col_wide[CAW-1:0];
                    value_next   = req.cell_value;
                    inside_next  = in_inside;
                    cnt_next     = '0;
                    unique case (in_op)
                        lgge_pkg::OP_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        lgge_pkg::OP_WRITE, lgge_pkg::OP_READ:
                        begin
                            mem_rd_en  = 1'b1;
                            state_next = S_ACCESS;
                        end
                        lgge_pkg::OP_ADVANCE:
                        begin
                            // fetch row 0, rows above it are dead
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = '0;
                            above_next  = '0;
                            cur_next    = '0;
                            state_next  = S_GEN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACCESS:
            begin
                // row word is in the read register: modify and reply
                if (can_push)
                begin
                    push            = 1'b1;
                    mem_wr_addr     = row_idx_reg;
                    mem_wr_en       = (op_reg == lgge_pkg::OP_WRITE) && inside_reg;
                    mem_wr_data     = value_reg ? (mem_rd_data | cell_bit)
                                                : (mem_rd_data & ~cell_bit);
                    read_value_next = (op_reg == lgge_pkg::OP_READ) && inside_reg
                                      && mem_rd_data[col_idx_reg];
                    state_next      = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                mem_wr_en = 1'b1;
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(ROWS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_REPLY;
                end
            end
            S_GEN:
            begin
                // read register holds row cnt; write back row cnt-1
                mem_wr_en   = (cnt_reg != '0);
                mem_wr_addr = cnt_m1[RAW-1:0];
                mem_wr_data = gen_row;
                mem_rd_en   = (cnt_p1 < (CW+1)'(ROWS));
                mem_rd_addr = cnt_p1[RAW-1:0];
                above_next  = cur_reg;
                cur_next    = mem_rd_data;
                cnt_next    = cnt_reg + CW'(1);
                if (!cnt_in_grid)
                begin
                    cnt_next   = '0;
                    state_next = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (can_push)
                begin
                    push            = 1'b1;
                    read_value_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        if (push)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
        op_reg         <= op_next;
        row_idx_reg    <= row_idx_next;
        col_idx_reg    <= col_idx_next;
        value_reg      <= value_next;
        inside_reg     <= inside_next;
        above_reg      <= above_next;
        cur_reg        <= cur_next;
    end

    // sweep never writes the row it is fetching
    `LGGE_ASSERT_NOW(a_gen_no_overlap, clk, rst_n, (state_reg == S_GEN) && mem_rd_en && mem_wr_en, mem_rd_addr != mem_wr_addr)

    // sweep pointer stays within the grid plus the final step
    `LGGE_ASSERT_NOW(a_gen_cnt_range, clk, rst_n, state_reg == S_GEN, cnt_reg <= CW'(ROWS))

    // a cell request moves to the access step right after acceptance
    `LGGE_ASSERT_NEXT(a_cell_access, clk, rst_n, in_accept && ((in_op == lgge_pkg::OP_WRITE) || (in_op == lgge_pkg::OP_READ)), state_reg == S_ACCESS)

endmodule

`default_nettype wire
